// ===== rtl/zku_pkg.sv =====
// Package for the position-key update block: payload word types, request and
// piece codes, the decoded operation word and the back-end state type.
// No dependencies.
package zku_pkg;

    localparam int KEY_W       = 64;
    localparam int ADDR_W      = 12;   // enough for 12 * 256 + 2 table slots
    localparam int RD_SLOTS    = 3;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [2:0] REQ_TABLE_WRITE = 3'd0;
    localparam logic [2:0] REQ_MOVE        = 3'd1;
    localparam logic [2:0] REQ_TOGGLE_SIDE = 3'd2;
    localparam logic [2:0] REQ_TOGGLE_NULL = 3'd3;
    localparam logic [2:0] REQ_BOARD       = 3'd4;

    localparam logic [2:0] PIECE_PAWN  = 3'd0;
    localparam logic [2:0] PIECE_QUEEN = 3'd4;
    localparam logic [2:0] PIECE_LIMIT = 3'd6;
    localparam logic [2:0] CAPT_PAWN   = 3'd1;
    localparam logic [2:0] CAPT_QUEEN  = 3'd5;
    localparam int         PIECE_TYPES = 6;

    typedef struct packed {
        logic [2:0]       req_type;
        logic [9:0]       table_index;
        logic [KEY_W-1:0] table_word;
        logic [5:0]       from_square;
        logic [5:0]       to_square;
        logic [2:0]       mover_type;
        logic             mover_black;
        logic [2:0]       captured_kind;
        logic             captured_black;
        logic             promotes;
        logic             square_occupied;
        logic             last_square;
    } t_in_item;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic             hash_done;
    } t_out_item;

    typedef enum logic [2:0] {
        K_NOP,
        K_WRITE_TABLE,
        K_WRITE_SIDE,
        K_WRITE_NULL,
        K_MOVE,
        K_TOGGLE_SIDE,
        K_TOGGLE_NULL,
        K_BOARD
    } t_kind;

    // Decoded operation: table reads are packed to the low slots.
    typedef struct packed {
        t_kind                           kind;
        logic [1:0]                      rd_cnt;
        logic [RD_SLOTS-1:0][ADDR_W-1:0] rd_addr;
        logic [ADDR_W-1:0]               wr_addr;
        logic [KEY_W-1:0]                wr_data;
        logic                            last;
    } t_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DONE
    } t_back_state;

endpackage

// ===== rtl/zku_front.sv =====
// Front end: classifies an input word and turns it into table addresses.
// Depends on zku_pkg.
module zku_front
    import zku_pkg::*;
#(
    parameter int SQUARES = 64
) (
    input  t_in_item i_item,
    output t_op      o_op
);

    localparam int          TW     = 12 * SQUARES;
    localparam logic [8:0]  SQ_LIM = 9'(SQUARES);

    logic [2:0]                      v_en;
    logic [RD_SLOTS-1:0][ADDR_W-1:0] v_addr;
    logic [1:0]                      v_cnt;
    logic                            v_from_ok;
    logic                            v_to_ok;
    logic                            v_mover_ok;
    logic [2:0]                      v_dest_type;

    function automatic logic [ADDR_W-1:0] tbl_addr(input logic blk,
                                                   input logic [2:0] typ,
                                                   input logic [5:0] sq);
        tbl_addr = (blk ? ADDR_W'(PIECE_TYPES * SQUARES) : '0)
                 + ADDR_W'(typ) * ADDR_W'(SQUARES) + ADDR_W'(sq);
    endfunction

    always_comb begin
        v_from_ok   = {3'b000, i_item.from_square} < SQ_LIM;
        v_to_ok     = {3'b000, i_item.to_square} < SQ_LIM;
        v_mover_ok  = i_item.mover_type < PIECE_LIMIT;
        v_dest_type = (i_item.mover_type == PIECE_PAWN && i_item.promotes)
                    ? PIECE_QUEEN : i_item.mover_type;
        v_en        = '0;
        v_addr      = '0;

        o_op         = '0;
        o_op.kind    = K_NOP;
        o_op.wr_addr = ADDR_W'(i_item.table_index);
        o_op.wr_data = i_item.table_word;
        o_op.last    = i_item.last_square;

        case (i_item.req_type)
            REQ_TABLE_WRITE: begin
                if (ADDR_W'(i_item.table_index) < ADDR_W'(TW)) begin
                    o_op.kind = K_WRITE_TABLE;
                end else if (ADDR_W'(i_item.table_index) == ADDR_W'(TW)) begin
                    o_op.kind = K_WRITE_SIDE;
                end else if (ADDR_W'(i_item.table_index) == ADDR_W'(TW + 1)) begin
                    o_op.kind = K_WRITE_NULL;
                end
            end
            REQ_MOVE: begin
                o_op.kind = K_MOVE;
                v_en[0]   = (i_item.captured_kind inside {[CAPT_PAWN:CAPT_QUEEN]})
                          && v_to_ok;
                v_addr[0] = tbl_addr(i_item.captured_black,
                                     i_item.captured_kind - 3'd1, i_item.to_square);
                v_en[1]   = v_mover_ok && v_from_ok;
                v_addr[1] = tbl_addr(i_item.mover_black, i_item.mover_type,
                                     i_item.from_square);
                v_en[2]   = v_mover_ok && v_to_ok;
                v_addr[2] = tbl_addr(i_item.mover_black, v_dest_type,
                                     i_item.to_square);
            end
            REQ_TOGGLE_SIDE: o_op.kind = K_TOGGLE_SIDE;
            REQ_TOGGLE_NULL: o_op.kind = K_TOGGLE_NULL;
            REQ_BOARD: begin
                o_op.kind = K_BOARD;
                v_en[0]   = i_item.square_occupied && v_mover_ok && v_to_ok;
                v_addr[0] = tbl_addr(i_item.mover_black, i_item.mover_type,
                                     i_item.to_square);
            end
            default: o_op.kind = K_NOP;
        endcase

        // Pack the needed reads into the low slots so the back end skips none.
        v_cnt = '0;
        for (int k = 0; k < RD_SLOTS; k++) begin
            if (v_en[k]) begin
                o_op.rd_addr[v_cnt] = v_addr[k];
                v_cnt               = v_cnt + 2'd1;
            end
        end
        o_op.rd_cnt = v_cnt;
    end

endmodule

// ===== rtl/zku_queue.sv =====
// Short queue of decoded operations between the front and back ends.
// Depends on zku_pkg.
module zku_queue
    import zku_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_op  i_op,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_op  o_op
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_op           r_slot [QUEUE_DEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [CW-1:0] r_count;
    logic [PW-1:0] n_wp;
    logic [PW-1:0] n_rp;
    logic [CW-1:0] n_count;

    assign o_full  = r_count == CW'(QUEUE_DEPTH);
    assign o_empty = r_count == '0;
    assign o_op    = r_slot[r_rp];

    always_comb begin
        n_wp    = r_wp;
        n_rp    = r_rp;
        n_count = r_count;
        if (i_push) begin
            n_wp = (r_wp == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (i_pop) begin
            n_rp = (r_rp == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_op;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop)
        else $error("pop from an empty queue");

endmodule

// ===== rtl/zku_back.sv =====
// Back end: table memory, side and null words, running key and board
// accumulator; reads one table word per cycle and commits into the output word.
// Depends on zku_pkg.
module zku_back
    import zku_pkg::*;
#(
    parameter int SQUARES = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_empty,
    input  t_op       i_q_op,
    output logic      o_q_pop,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    localparam int TW = 12 * SQUARES;
    localparam int AW = $clog2(TW);

    logic [KEY_W-1:0] r_mem [TW];

    t_back_state      r_state;
    t_back_state      n_state;
    t_op              r_op;
    t_op              n_op;
    logic [1:0]       r_slot;
    logic [1:0]       n_slot;
    logic [KEY_W-1:0] r_acc;
    logic [KEY_W-1:0] n_acc;
    logic             r_pend;
    logic             n_pend;
    logic [KEY_W-1:0] r_rdata;
    logic [KEY_W-1:0] r_key;
    logic [KEY_W-1:0] n_key;
    logic [KEY_W-1:0] r_board;
    logic [KEY_W-1:0] n_board;
    logic [KEY_W-1:0] r_side;
    logic [KEY_W-1:0] n_side;
    logic [KEY_W-1:0] r_null;
    logic [KEY_W-1:0] n_null;
    logic             r_out_valid;
    logic             n_out_valid;
    t_out_item        r_out;
    t_out_item        n_out;

    logic             rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic             wr_en;
    logic             load;
    logic             commit;
    logic [KEY_W-1:0] xsum;
    logic [KEY_W-1:0] bsum;

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;
    assign rd_addr     = r_op.rd_addr[r_slot];

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_slot      = r_slot;
        n_acc       = r_acc;
        n_pend      = r_pend;
        n_key       = r_key;
        n_board     = r_board;
        n_side      = r_side;
        n_null      = r_null;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        rd_en       = 1'b0;
        wr_en       = 1'b0;
        load        = 1'b0;
        commit      = 1'b0;
        o_q_pop     = 1'b0;

        // Read data of the previous cycle folds into the partial sum.
        xsum = r_acc ^ (r_pend ? r_rdata : '0);
        bsum = r_board ^ xsum;

        case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    load = 1'b1;
                end
            end
            S_RUN: begin
                rd_en  = 1'b1;
                n_acc  = xsum;
                n_pend = 1'b1;
                if (r_slot == r_op.rd_cnt - 2'd1) begin
                    n_state = S_DONE;
                end else begin
                    n_slot = r_slot + 2'd1;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    commit = 1'b1;
                    if (!i_q_empty) begin
                        load = 1'b1;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (commit) begin
            n_out_valid = 1'b1;
            n_out.hash_done = 1'b0;
            case (r_op.kind)
                K_WRITE_TABLE: wr_en = 1'b1;
                K_WRITE_SIDE:  n_side = r_op.wr_data;
                K_WRITE_NULL:  n_null = r_op.wr_data;
                K_MOVE:        n_key = r_key ^ xsum;
                K_TOGGLE_SIDE: n_key = r_key ^ r_side;
                K_TOGGLE_NULL: n_key = r_key ^ r_null;
                K_BOARD: begin
                    if (r_op.last) begin
                        n_key           = bsum;
                        n_board         = '0;
                        n_out.hash_done = 1'b1;
                    end else begin
                        n_board = bsum;
                    end
                end
                default: n_key = r_key;
            endcase
            n_out.key = n_key;
        end

        if (load) begin
            o_q_pop = 1'b1;
            n_op    = i_q_op;
            n_acc   = '0;
            n_pend  = 1'b0;
            n_slot  = '0;
            n_state = (i_q_op.rd_cnt != 2'd0) ? S_RUN : S_DONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pend      <= 1'b0;
            r_key       <= '0;
            r_board     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pend      <= n_pend;
            r_key       <= n_key;
            r_board     <= n_board;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op   <= n_op;
        r_slot <= n_slot;
        r_acc  <= n_acc;
        r_side <= n_side;
        r_null <= n_null;
        r_out  <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_op.wr_addr[AW-1:0]] <= r_op.wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr[AW-1:0]];
        end
    end

    a_slot_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (r_op.rd_cnt != 2'd0 && r_slot < r_op.rd_cnt))
        else $error("read slot outside the operation's read list");

    a_done_clears_board: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.hash_done) |-> (r_board == '0))
        else $error("board accumulator not cleared after a recompute");

    a_no_write_while_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(rd_en && wr_en))
        else $error("table read and write in the same cycle");

endmodule

// ===== rtl/zobrist_key_update_core.sv =====
// Position-key update core. An item passes the queue and the back end, which
// reads its table words one at a time (a move reads up to three) and then
// registers the result. Throughput is set by the single table memory port:
// writes and toggles read no table word, an occupied board square reads one.
// Synchronous active-low reset clears the key, the board sum and all control;
// the table and the side and null words hold garbage until written.
module zobrist_key_update_core
    import zku_pkg::*;
#(
    parameter int SQUARES = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    t_op  front_op;
    t_op  q_op;
    logic q_full;
    logic q_empty;
    logic q_pop;
    logic push;

    assign o_in_stall = q_full;
    assign push       = i_in_valid && !q_full;

    zku_front #(
        .SQUARES (SQUARES)
    ) u_front (
        .i_item (i_in_item),
        .o_op   (front_op)
    );

    zku_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (front_op),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_op    (q_op)
    );

    zku_back #(
        .SQUARES (SQUARES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_q_op      (q_op),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule
